// ===== hw/rtl/mbc_pkg.sv =====
// maze carver package: types, state codes and size constants
// used by maze_backtracker_carver_top; depends on nothing
`default_nettype none
package mbc_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    // width of the effective grid limits, holds up to 65535
    localparam int LIM_W          = 16;
    localparam int CFG_W          = 7;
    localparam int CFG_IDX_W      = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    // move directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef struct packed {
        logic        restart;
        logic [30:0] random_value;
    } t_in_word;

    typedef struct packed {
        logic       carved;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [1:0] direction;
        logic [7:0] wall_x;
        logic [7:0] wall_y;
        logic       done_res;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_INIT,
        ST_IDLE,
        ST_POP,
        ST_POP_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_PICK,
        ST_PUSH_A,
        ST_PUSH_B,
        ST_RESULT
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/mbc_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none
module mbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/maze_backtracker_carver_top.sv =====
// maze carver top level: sequencer, neighbour unit, visited map and room stack
// depends on mbc_pkg and mbc_ram
`default_nettype none
// Usage:
// Input channel (i_in_valid / o_in_stall / i_in_word): each word carries one
// random value and a restart flag. Output channel (o_out_valid / i_out_stall /
// o_out_word): exactly one result word per input word, in order.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets grid
// width, index 1 grid height; write only while the block is idle.
// One word is processed at a time; o_in_stall is high while it is in work.
// Each stack pop reads the stack, probes the four visited-map neighbours
// one by one through the shared neighbour unit and then picks; a carve
// adds two stack pushes and the result. A word may pop several rooms; an
// empty stack answers done. A restart first sweeps the visited map.
// Reset: the same sweep runs after reset, input is stalled meanwhile;
// config writes are taken. Registers reset to 8.
// A stalled result sits in the output register; the next word can be
// accepted and processed, and waits in the result state only if the
// previous result is still not taken.
module maze_backtracker_carver_top
    import mbc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int ROOMS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SW    = XW + YW;
    localparam int CW    = $clog2(ROOMS + 1);

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [AW-1:0]    r_clr;
    logic [CW-1:0]    r_count, n_count;
    logic             r_pending;
    logic [XW-1:0]    r_x;
    logic [YW-1:0]    r_y;
    logic [1:0]       r_dir, n_dir;
    logic [3:0]       r_free;
    logic             r_nb_ok;
    logic             r_done;
    logic [1:0]       r_rnd_lo;
    logic [1:0]       r_rnd_mod3;
    logic             r_out_valid;
    t_out_word        r_out, n_out;

    logic             accept;
    logic             out_load;
    logic [LIM_W-1:0] lim_w, lim_h;

    // ram controls
    logic             vis_we, vis_wdata, vis_rdata;
    logic [AW-1:0]    vis_waddr, vis_raddr;
    logic             stk_we;
    logic [AW-1:0]    stk_waddr, stk_raddr;
    logic [SW-1:0]    stk_wdata, stk_rdata;

    // neighbour unit
    logic             nb_ok;
    logic [XW-1:0]    nb_x;
    logic [YW-1:0]    nb_y;
    logic [AW-1:0]    nb_addr;
    logic [XW+1:0]    nb_wx;
    logic [YW+1:0]    nb_wy;

    // pick unit
    logic [2:0]       free_cnt;
    logic [1:0]       sel, pick_dir, pick_cnt;
    logic             pick_found;
    logic [CW:0]      count_p2;

    // mod 3 of the random word
    logic [31:0]      rnd_ext;
    logic [5:0]       m3_sum;
    logic [3:0]       m3_fold;
    logic [1:0]       rnd_mod3;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign out_load    = (r_state == ST_RESULT) && (!r_out_valid || !i_out_stall);
    assign rnd_ext     = {1'b0, i_in_word.random_value};

    // effective grid limits: zero counts as one, saturate at the maximum
    always_comb begin
        lim_w = LIM_W'(r_cfg_w);
        if (r_cfg_w == '0) begin
            lim_w = LIM_W'(1);
        end else if (LIM_W'(r_cfg_w) > LIM_W'(MAX_WIDTH)) begin
            lim_w = LIM_W'(MAX_WIDTH);
        end
        lim_h = LIM_W'(r_cfg_h);
        if (r_cfg_h == '0) begin
            lim_h = LIM_W'(1);
        end else if (LIM_W'(r_cfg_h) > LIM_W'(MAX_HEIGHT)) begin
            lim_h = LIM_W'(MAX_HEIGHT);
        end
    end

    // random word mod 3 by folding base-4 digits
    always_comb begin
        m3_sum = '0;
        for (int i = 0; i < 16; i++) begin
            m3_sum = m3_sum + 6'(rnd_ext[2*i +: 2]);
        end
        m3_fold = 4'(m3_sum[1:0]) + 4'(m3_sum[3:2]) + 4'(m3_sum[5:4]);
        if (m3_fold >= 4'd6) begin
            rnd_mod3 = 2'(m3_fold - 4'd6);
        end else if (m3_fold >= 4'd3) begin
            rnd_mod3 = 2'(m3_fold - 4'd3);
        end else begin
            rnd_mod3 = 2'(m3_fold);
        end
    end

    // shared neighbour unit: bounds test on both coordinates, map address, wall
    always_comb begin
        nb_x  = r_x;
        nb_y  = r_y;
        nb_wx = {2'b00, r_x} + {2'b00, r_x} + (XW+2)'(1);
        nb_wy = {2'b00, r_y} + {2'b00, r_y} + (YW+2)'(1);
        unique case (r_dir)
            DIR_UP: begin
                nb_ok = (r_y != '0) && (LIM_W'(r_y) <= lim_h) &&
                        (LIM_W'(r_x) < lim_w);
                nb_y  = r_y - YW'(1);
                nb_wy = nb_wy - (YW+2)'(1);
            end
            DIR_RIGHT: begin
                nb_ok = ((LIM_W'(r_x) + LIM_W'(1)) < lim_w) &&
                        (LIM_W'(r_y) < lim_h);
                nb_x  = r_x + XW'(1);
                nb_wx = nb_wx + (XW+2)'(1);
            end
            DIR_DOWN: begin
                nb_ok = ((LIM_W'(r_y) + LIM_W'(1)) < lim_h) &&
                        (LIM_W'(r_x) < lim_w);
                nb_y  = r_y + YW'(1);
                nb_wy = nb_wy + (YW+2)'(1);
            end
            default: begin
                nb_ok = (r_x != '0) && (LIM_W'(r_x) <= lim_w) &&
                        (LIM_W'(r_y) < lim_h);
                nb_x  = r_x - XW'(1);
                nb_wx = nb_wx - (XW+2)'(1);
            end
        endcase
        nb_addr = AW'(AW'(nb_y) * AW'(MAX_WIDTH)) + AW'(nb_x);
    end

    // choose entry (random mod count) among free neighbours
    always_comb begin
        free_cnt = 3'($countones(r_free));
        unique case (free_cnt)
            3'd2:    sel = {1'b0, r_rnd_lo[0]};
            3'd3:    sel = r_rnd_mod3;
            3'd4:    sel = r_rnd_lo;
            default: sel = 2'd0;
        endcase
        pick_dir   = DIR_UP;
        pick_cnt   = 2'd0;
        pick_found = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r_free[i] && !pick_found) begin
                if (pick_cnt == sel) begin
                    pick_dir   = 2'(i);
                    pick_found = 1'b1;
                end
                pick_cnt = pick_cnt + 2'd1;
            end
        end
        count_p2 = {1'b0, r_count} + (CW+1)'(2);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:    if (r_clr == AW'(ROOMS - 1)) n_state = ST_INIT;
            ST_INIT:     n_state = r_pending ? ST_POP : ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    n_state = i_in_word.restart ? ST_CLEAR : ST_POP;
                end
            end
            ST_POP:      n_state = (r_count == '0) ? ST_RESULT : ST_POP_WAIT;
            ST_POP_WAIT: n_state = ST_SCAN_RD;
            ST_SCAN_RD:  n_state = ST_SCAN_CK;
            ST_SCAN_CK:  n_state = (r_dir == DIR_LEFT) ? ST_PICK : ST_SCAN_RD;
            ST_PICK: begin
                if (free_cnt == '0 || count_p2 > (CW+1)'(ROOMS)) begin
                    n_state = ST_POP;
                end else begin
                    n_state = ST_PUSH_A;
                end
            end
            ST_PUSH_A:   n_state = ST_PUSH_B;
            ST_PUSH_B:   n_state = ST_RESULT;
            ST_RESULT:   if (out_load) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ram controls, stack count, direction and result word
    always_comb begin
        vis_we    = 1'b0;
        vis_waddr = r_clr;
        vis_wdata = 1'b0;
        vis_raddr = nb_addr;
        stk_we    = 1'b0;
        stk_waddr = r_count[AW-1:0];
        stk_wdata = {r_y, r_x};
        stk_raddr = AW'(r_count - CW'(1));
        n_count   = r_count;
        n_dir     = r_dir;
        n_out     = '0;
        unique case (r_state)
            ST_CLEAR: begin
                vis_we = 1'b1;
            end
            ST_INIT: begin
                vis_we    = 1'b1;
                vis_waddr = '0;
                vis_wdata = 1'b1;
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = '0;
                n_count   = CW'(1);
            end
            ST_POP: begin
                if (r_count != '0) begin
                    n_count = r_count - CW'(1);
                end
            end
            ST_POP_WAIT: begin
                n_dir = DIR_UP;
            end
            ST_SCAN_CK: begin
                n_dir = r_dir + 2'd1;
            end
            ST_PICK: begin
                n_dir = pick_dir;
            end
            ST_PUSH_A: begin
                stk_we    = 1'b1;
                vis_we    = 1'b1;
                vis_waddr = nb_addr;
                vis_wdata = 1'b1;
                n_count   = r_count + CW'(1);
            end
            ST_PUSH_B: begin
                stk_we    = 1'b1;
                stk_wdata = {nb_y, nb_x};
                n_count   = r_count + CW'(1);
            end
            ST_RESULT: begin
                if (r_done) begin
                    n_out.done_res = 1'b1;
                end else begin
                    n_out.carved    = 1'b1;
                    n_out.cell_x    = 6'(nb_x);
                    n_out.cell_y    = 6'(nb_y);
                    n_out.direction = r_dir;
                    n_out.wall_x    = 8'(nb_wx);
                    n_out.wall_y    = 8'(nb_wy);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_w     <= CFG_RESET;
            r_cfg_h     <= CFG_RESET;
            r_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_GRID_WIDTH) begin
                    r_cfg_w <= i_cfg_data;
                end else if (i_cfg_index == REG_GRID_HEIGHT) begin
                    r_cfg_h <= i_cfg_data;
                end
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end else begin
                r_clr <= '0;
            end
            if (accept) begin
                r_pending <= 1'b1;
                r_done    <= 1'b0;
            end else if (r_state == ST_RESULT) begin
                r_pending <= 1'b0;
            end
            if (r_state == ST_POP && r_count == '0) begin
                r_done <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dir <= n_dir;
        if (accept) begin
            r_rnd_lo   <= i_in_word.random_value[1:0];
            r_rnd_mod3 <= rnd_mod3;
        end
        if (r_state == ST_POP_WAIT) begin
            r_x    <= stk_rdata[XW-1:0];
            r_y    <= stk_rdata[SW-1:XW];
            r_free <= '0;
        end
        if (r_state == ST_SCAN_RD) begin
            r_nb_ok <= nb_ok;
        end
        if (r_state == ST_SCAN_CK && r_nb_ok && !vis_rdata) begin
            r_free[r_dir] <= 1'b1;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // visited map and room stack
    mbc_ram #(.WIDTH(1), .DEPTH(ROOMS)) u_visited (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vis_raddr),
        .o_rdata (vis_rdata)
    );

    mbc_ram #(.WIDTH(SW), .DEPTH(ROOMS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

`ifndef SYNTHESIS
    // stack never grows past the room count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ROOMS))
        else $error("room stack overflow");

    // a done result never reports a carve
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.done_res |-> !o_out_word.carved)
        else $error("done result with carve");

    // a restart word starts the map sweep
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_word.restart |=> r_state == ST_CLEAR)
        else $error("restart did not clear map");

    // the first of the two carve pushes adds one stack entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PUSH_A |=> r_count == $past(r_count) + CW'(1))
        else $error("push count mismatch");
`endif

endmodule
`default_nettype wire
